>>> rtl/assert_macros.svh
// assertion macros shared by the vertex dedup indexer rtl
// depends on clk_i and rst_ni in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion checked on every rising clock edge outside reset
`define VDI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// assertion checked on every rising clock edge, reset included
`define VDI_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/vdi_pkg.sv
// shared types and constants of the vertex dedup indexer
// no dependencies
package vdi_pkg;

  localparam int unsigned TableDepth = 1024;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = $clog2(TableDepth + 1);
  localparam int unsigned WordW      = 32;
  localparam int unsigned KeyW       = 8 * WordW;
  localparam int unsigned IndexOutW  = 10;

  // one queued vertex transaction
  typedef struct packed {
    logic            start;
    logic [KeyW-1:0] key;
  } item_t;

  // one result transaction
  typedef struct packed {
    logic                 valid;
    logic [IndexOutW-1:0] index;
    logic                 is_new;
    logic                 overflow;
  } result_t;

  typedef enum logic [1:0] {
    BkIdle,
    BkRead,
    BkCmp,
    BkDecide
  } back_state_e;

endpackage

>>> rtl/vdi_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module vdi_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> rtl/vdi_front.sv
// front end: accepts vertex transactions into a two entry queue
// depends on vdi_pkg and assert_macros.svh
`include "assert_macros.svh"

module vdi_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  vdi_pkg::item_t item_i,
  output logic           full_o,
  output logic           avail_o,
  output vdi_pkg::item_t item_o,
  input  logic           pop_i
);

  vdi_pkg::item_t slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign full_o  = (cnt_q == 2'd2);
  assign avail_o = (cnt_q != 2'd0);
  assign item_o  = slot_q[rd_ptr_q];
  assign push    = push_i && !full_o;
  assign pop     = pop_i && avail_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  `VDI_ASSERT(a_cnt_range, (cnt_q != 2'd3), "queue count out of range")
  `VDI_ASSERT(a_ptr_match, (cnt_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q),
              "queue pointers disagree with count")

endmodule

>>> rtl/vdi_back.sv
// back end: scans the key table, inserts new vertices, drives results
// depends on vdi_pkg, vdi_ram and assert_macros.svh
`include "assert_macros.svh"

module vdi_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            avail_i,
  input  vdi_pkg::item_t  item_i,
  output logic            pop_o,
  output vdi_pkg::result_t result_o
);

  vdi_pkg::back_state_e           state_q, state_d;
  logic [vdi_pkg::KeyW-1:0]       key_q, key_d;
  logic [vdi_pkg::CntW-1:0]       limit_q, limit_d;
  logic [vdi_pkg::CntW-1:0]       count_q, count_d;
  logic [vdi_pkg::IdxW-1:0]       addr_q, addr_d;
  vdi_pkg::result_t               res_q, res_d;
  logic                           re, we;
  logic [vdi_pkg::KeyW-1:0]       rdata;
  logic [vdi_pkg::CntW-1:0]       next_addr;

  assign next_addr = vdi_pkg::CntW'(addr_q) + vdi_pkg::CntW'(1);

  // key table, indexed by insertion order
  vdi_ram #(
    .Width(vdi_pkg::KeyW),
    .Depth(vdi_pkg::TableDepth)
  ) u_keys (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(limit_q[vdi_pkg::IdxW-1:0]),
    .wdata_i(key_q),
    .re_i   (re),
    .raddr_i(addr_q),
    .rdata_o(rdata)
  );

  // scan sequencer
  always_comb begin
    state_d = state_q;
    key_d   = key_q;
    limit_d = limit_q;
    count_d = count_q;
    addr_d  = addr_q;
    res_d   = '0;
    pop_o   = 1'b0;
    re      = 1'b0;
    we      = 1'b0;
    unique case (state_q)
      vdi_pkg::BkIdle: begin
        if (avail_i) begin
          pop_o   = 1'b1;
          key_d   = item_i.key;
          limit_d = item_i.start ? '0 : count_q;
          count_d = limit_d;
          addr_d  = '0;
          state_d = (limit_d == '0) ? vdi_pkg::BkDecide : vdi_pkg::BkRead;
        end
      end
      vdi_pkg::BkRead: begin
        re      = 1'b1;
        state_d = vdi_pkg::BkCmp;
      end
      vdi_pkg::BkCmp: begin
        if (rdata == key_q) begin
          res_d.valid = 1'b1;
          res_d.index = vdi_pkg::IndexOutW'(addr_q);
          state_d     = vdi_pkg::BkIdle;
        end else if (next_addr == limit_q) begin
          state_d = vdi_pkg::BkDecide;
        end else begin
          addr_d  = next_addr[vdi_pkg::IdxW-1:0];
          state_d = vdi_pkg::BkRead;
        end
      end
      vdi_pkg::BkDecide: begin
        res_d.valid = 1'b1;
        if (limit_q == vdi_pkg::CntW'(vdi_pkg::TableDepth)) begin
          res_d.overflow = 1'b1;
        end else begin
          we           = 1'b1;
          count_d      = limit_q + vdi_pkg::CntW'(1);
          res_d.index  = vdi_pkg::IndexOutW'(limit_q);
          res_d.is_new = 1'b1;
        end
        state_d = vdi_pkg::BkIdle;
      end
      default: state_d = vdi_pkg::BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vdi_pkg::BkIdle;
      count_q <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      res_q   <= res_d;
    end
  end

  // working registers of the current transaction
  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    limit_q <= limit_d;
    addr_q  <= addr_d;
  end

  assign result_o = res_q;

  `VDI_ASSERT(a_flags_excl, res_q.valid |-> !(res_q.is_new && res_q.overflow),
              "new and overflow both set")
  `VDI_ASSERT(a_count_range, (count_q <= vdi_pkg::CntW'(vdi_pkg::TableDepth)),
              "unique count above table depth")
  `VDI_ASSERT(a_new_counts, (res_q.valid && res_q.is_new) |->
              (count_q == $past(limit_q) + vdi_pkg::CntW'(1)),
              "new vertex did not advance the count")
  `VDI_ASSERT(a_overflow_full, (res_q.valid && res_q.overflow) |->
              (count_q == vdi_pkg::CntW'(vdi_pkg::TableDepth)),
              "overflow reported with free entries")

endmodule

>>> rtl/vertex_dedup_indexer_unit.sv
// Vertex dedup indexer: maps each packed vertex to an index in insertion order.
// Command channel: a transaction is taken at a rising edge with start high and
// busy low; start_of_mesh_i empties the table before that vertex is handled.
// Result channel: result_valid_o is high for exactly one cycle with
// vtx_index_o, is_new_vertex_o and table_overflow_o; it cannot be stalled.
// A two entry queue in front lets a new command in while the back end scans.
// The back end scans the n stored keys from index 0 on, one vertex at a time;
// each compare is a read of the key ram followed by a compare, and a hit
// ends the scan. Busy stays high while the queue holds two transactions.
// A vertex not found is written at index n; a full table reports overflow.
// Reset empties the queue and the table count; the key ram needs no clearing.
// depends on vdi_pkg, vdi_front and vdi_back
module vertex_dedup_indexer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        start_of_mesh_i,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [31:0] pos_z_i,
  input  logic [31:0] norm_x_i,
  input  logic [31:0] norm_y_i,
  input  logic [31:0] norm_z_i,
  input  logic [31:0] tex_u_i,
  input  logic [31:0] tex_v_i,
  output logic        result_valid_o,
  output logic [9:0]  vtx_index_o,
  output logic        is_new_vertex_o,
  output logic        table_overflow_o
);

  vdi_pkg::item_t   in_item, q_item;
  vdi_pkg::result_t res;
  logic             full, avail, pop;

  // pack the vertex attributes into one key
  assign in_item.start = start_of_mesh_i;
  assign in_item.key   = {tex_v_i, tex_u_i, norm_z_i, norm_y_i, norm_x_i,
                          pos_z_i, pos_y_i, pos_x_i};
  assign busy          = full;

  vdi_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (start),
    .item_i (in_item),
    .full_o (full),
    .avail_o(avail),
    .item_o (q_item),
    .pop_i  (pop)
  );

  vdi_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (avail),
    .item_i  (q_item),
    .pop_o   (pop),
    .result_o(res)
  );

  assign result_valid_o   = res.valid;
  assign vtx_index_o      = res.index;
  assign is_new_vertex_o  = res.is_new;
  assign table_overflow_o = res.overflow;

endmodule
